[hw/rtl/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    localparam int CHAIN_WORDS = 5;

    typedef logic [31:0] word_t;
    typedef logic [2:0]  chain_idx_t;
    typedef logic [3:0]  blk_idx_t;

    localparam word_t H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    // last fill count at which 0x80 and the length still fit in one block
    localparam logic [5:0] PAD_LAST_FIT = 6'd55;

    typedef struct packed {
        logic       shift_en;
        logic       round_en;
        logic       from_mem;
        logic [1:0] phase;
    } sha1_rnd_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/sha1_block_ram.sv]
// ----------------------------------------------------------------------------
// sha1_block_ram
// 16 x 32 block store, one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_block_ram (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire sha1_pkg::blk_idx_t addr,
    input  wire sha1_pkg::word_t   wdata,
    output sha1_pkg::word_t        rdata
);
    import sha1_pkg::*;

    word_t mem [16];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/sha1_chain_store.sv]
// ----------------------------------------------------------------------------
// sha1_chain_store
// Chaining word memory; entries not written since the last clear read as
// the SHA-1 initial values.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_chain_store (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 we,
    input  wire sha1_pkg::chain_idx_t waddr,
    input  wire sha1_pkg::word_t      wdata,
    input  wire sha1_pkg::chain_idx_t raddr,
    input  wire logic                 clear,
    output sha1_pkg::word_t           rdata
);
    import sha1_pkg::*;

    word_t                  mem [CHAIN_WORDS];
    logic [CHAIN_WORDS-1:0] valid_reg;
    word_t                  rd_reg;
    logic                   rd_valid_reg;
    chain_idx_t             rd_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg       <= mem[raddr];
        rd_valid_reg <= valid_reg[raddr];
        rd_addr_reg  <= raddr;
    end

    assign rdata = rd_valid_reg ? rd_reg : H_INIT[rd_addr_reg];

endmodule

`default_nettype wire

[hw/rtl/sha1_round_unit.sv]
// ----------------------------------------------------------------------------
// sha1_round_unit
// Working words a..e and the 16-word schedule window; one round per cycle while round_en is set.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_round_unit (
    input  wire logic                     clk,
    input  wire sha1_pkg::sha1_rnd_ctrl_t ctrl,
    input  wire sha1_pkg::word_t          shift_in,
    input  wire sha1_pkg::word_t          blk_word,
    output sha1_pkg::word_t               a_word
);
    import sha1_pkg::*;

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t w_reg [16];
    word_t w_mix;
    word_t w_cur;
    word_t f_val;
    word_t t_val;

    always_comb
    begin
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_cur = ctrl.from_mem ? blk_word : {w_mix[30:0], w_mix[31]};
        case (ctrl.phase)
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd2:    f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_cur + K_ROUND[ctrl.phase];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
        end
        else if (ctrl.shift_en)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
            e_reg <= shift_in;
        end
    end

    assign a_word = a_reg;

endmodule

`default_nettype wire

[hw/rtl/sha1_message_digest.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest
// Byte-streaming SHA-1: block store, chaining store and one-round-per-cycle
// compression, with padding and digest output.
// ----------------------------------------------------------------------------
// Throughput: one byte request per cycle while idle; every 64th byte starts a
//   compression (load, 80 rounds from the round unit, fold-back) that holds off input.
// End of message: padding written into the block RAM, one or two
//   compressions, then 5 digest words, each read, loaded and held until taken.
// Reset: control cleared at once; chaining words read as the initial values
//   through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,   // message_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic             m_tlast    // word_last
);
    import sha1_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PAD_FIRST = 4'd1;
    localparam logic [3:0] S_PAD       = 4'd2;
    localparam logic [3:0] S_LOAD      = 4'd3;
    localparam logic [3:0] S_ROUND     = 4'd4;
    localparam logic [3:0] S_FOLD      = 4'd5;
    localparam logic [3:0] S_OUT_RD    = 4'd6;
    localparam logic [3:0] S_OUT_LD    = 4'd7;
    localparam logic [3:0] S_OUT       = 4'd8;

    localparam logic [1:0] POST_IDLE      = 2'd0;
    localparam logic [1:0] POST_PAD_FIRST = 2'd1;
    localparam logic [1:0] POST_PAD       = 2'd2;
    localparam logic [1:0] POST_OUT       = 2'd3;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  post_reg, post_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [23:0] acc_reg, acc_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [4:0]  wptr_reg, wptr_next;
    logic        long_reg, long_next;
    chain_idx_t  out_idx_reg, out_idx_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        m_tlast_reg, m_tlast_next;
    word_t       m_tdata_reg, m_tdata_next;

    logic           blk_we;
    blk_idx_t       blk_addr;
    word_t          blk_wdata;
    word_t          blk_rdata;
    logic           ch_we;
    chain_idx_t     ch_waddr;
    word_t          ch_wdata;
    chain_idx_t     ch_raddr;
    logic           ch_clear;
    word_t          ch_rdata;
    sha1_rnd_ctrl_t rnd_ctrl;
    word_t          a_word;
    word_t          pad_word;
    logic           in_req;

    assign s_tready = (state_reg == S_IDLE);
    assign in_req   = s_tvalid && s_tready;

    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {acc_reg[23:0], PAD_BYTE};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        post_next      = post_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        bit_count_next = bit_count_reg;
        wptr_next      = wptr_reg;
        long_next      = long_reg;
        out_idx_next   = out_idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tlast_next   = m_tlast_reg;
        m_tdata_next   = m_tdata_reg;
        blk_we         = 1'b0;
        blk_addr       = fill_reg[5:2];
        blk_wdata      = '0;
        ch_we          = 1'b0;
        ch_waddr       = '0;
        ch_wdata       = '0;
        ch_raddr       = '0;
        ch_clear       = 1'b0;
        rnd_ctrl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    if (s_tuser)
                    begin
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            blk_we    = 1'b1;
                            blk_wdata = {acc_reg, s_tdata};
                        end
                        acc_next       = {acc_reg[15:0], s_tdata};
                        fill_next      = fill_reg + 6'd1;
                        bit_count_next = bit_count_reg + 64'd8;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = S_LOAD;
                            cnt_next   = '0;
                            post_next  = s_tlast ? POST_PAD_FIRST : POST_IDLE;
                        end
                        else if (s_tlast)
                        begin
                            state_next = S_PAD_FIRST;
                        end
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_PAD_FIRST;
                    end
                end
            end

            S_PAD_FIRST:
            begin
                blk_we     = 1'b1;
                blk_wdata  = pad_word;
                wptr_next  = {1'b0, fill_reg[5:2]} + 5'd1;
                long_next  = (fill_reg > PAD_LAST_FIT);
                state_next = S_PAD;
            end

            S_PAD:
            begin
                if (wptr_reg[4])
                begin
                    state_next = S_LOAD;
                    cnt_next   = '0;
                    post_next  = POST_PAD;
                    wptr_next  = '0;
                    long_next  = 1'b0;
                end
                else
                begin
                    blk_we   = 1'b1;
                    blk_addr = wptr_reg[3:0];
                    if (!long_reg && wptr_reg[3:0] == 4'd14)
                    begin
                        blk_wdata = bit_count_reg[63:32];
                    end
                    else if (!long_reg && wptr_reg[3:0] == 4'd15)
                    begin
                        blk_wdata = bit_count_reg[31:0];
                    end
                    wptr_next = wptr_reg + 5'd1;
                    if (!long_reg && wptr_reg[3:0] == 4'd15)
                    begin
                        state_next = S_LOAD;
                        cnt_next   = '0;
                        post_next  = POST_OUT;
                    end
                end
            end

            S_LOAD:
            begin
                ch_raddr          = cnt_reg[2:0];
                rnd_ctrl.shift_en = (cnt_reg != 7'd0);
                if (cnt_reg == 7'd5)
                begin
                    blk_addr   = '0;
                    state_next = S_ROUND;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            S_ROUND:
            begin
                rnd_ctrl.round_en = 1'b1;
                rnd_ctrl.from_mem = (cnt_reg < 7'd16);
                if (cnt_reg < 7'd20)
                begin
                    rnd_ctrl.phase = 2'd0;
                end
                else if (cnt_reg < 7'd40)
                begin
                    rnd_ctrl.phase = 2'd1;
                end
                else if (cnt_reg < 7'd60)
                begin
                    rnd_ctrl.phase = 2'd2;
                end
                else
                begin
                    rnd_ctrl.phase = 2'd3;
                end
                blk_addr = cnt_reg[3:0] + 4'd1;
                if (cnt_reg == 7'd79)
                begin
                    state_next = S_FOLD;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            S_FOLD:
            begin
                ch_raddr = cnt_reg[2:0];
                if (cnt_reg != 7'd0)
                begin
                    ch_we             = 1'b1;
                    ch_waddr          = cnt_reg[2:0] - 3'd1;
                    ch_wdata          = ch_rdata + a_word;
                    rnd_ctrl.shift_en = 1'b1;
                end
                if (cnt_reg == 7'd5)
                begin
                    cnt_next = '0;
                    case (post_reg)
                        POST_PAD_FIRST: state_next = S_PAD_FIRST;
                        POST_PAD:       state_next = S_PAD;
                        POST_OUT:
                        begin
                            state_next   = S_OUT_RD;
                            out_idx_next = '0;
                        end
                        default:        state_next = S_IDLE;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            S_OUT_RD:
            begin
                ch_raddr   = out_idx_reg;
                state_next = S_OUT_LD;
            end

            S_OUT_LD:
            begin
                m_tdata_next  = ch_rdata;
                m_tvalid_next = 1'b1;
                m_tlast_next  = (out_idx_reg == 3'(CHAIN_WORDS - 1));
                state_next    = S_OUT;
            end

            S_OUT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (out_idx_reg == 3'(CHAIN_WORDS - 1))
                    begin
                        ch_clear       = 1'b1;
                        fill_next      = '0;
                        bit_count_next = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                        state_next   = S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            post_reg      <= POST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            bit_count_reg <= '0;
            wptr_reg      <= '0;
            long_reg      <= 1'b0;
            out_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            post_reg      <= post_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            bit_count_reg <= bit_count_next;
            wptr_reg      <= wptr_next;
            long_reg      <= long_next;
            out_idx_reg   <= out_idx_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tlast_reg   <= m_tlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    sha1_block_ram u_block_ram (
        .clk   (clk),
        .we    (blk_we),
        .addr  (blk_addr),
        .wdata (blk_wdata),
        .rdata (blk_rdata)
    );

    sha1_chain_store u_chain_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .clear (ch_clear),
        .rdata (ch_rdata)
    );

    sha1_round_unit u_round_unit (
        .clk      (clk),
        .ctrl     (rnd_ctrl),
        .shift_in (ch_rdata),
        .blk_word (blk_rdata),
        .a_word   (a_word)
    );

    ast_no_input_during_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid
    ) else $error("input request taken while a digest word is pending");

    ast_round_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (cnt_reg < 7'd80)
    ) else $error("round counter out of range");

    ast_pad_short_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD && !long_reg) |-> !wptr_reg[4]
    ) else $error("single-block padding ran past the length words");

    ast_blk_write_window: assert property (
        @(posedge clk) disable iff (!rst_n)
        blk_we |-> (state_reg == S_IDLE || state_reg == S_PAD_FIRST || state_reg == S_PAD)
    ) else $error("block store written during compression");

    ast_chain_write_fold: assert property (
        @(posedge clk) disable iff (!rst_n)
        ch_we |-> (state_reg == S_FOLD && $past(state_reg) == S_FOLD)
    ) else $error("chaining store written outside fold-back");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream SHA-1 bench: feeds messages one byte request at a time, keeps
// its own SHA-1 hash state and checks each digest word and its last flag.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TIME  = 400;
    localparam int RANDOM_SPLIT = 200;
    localparam int RANDOM_TOTAL = 380;
    localparam int TOTAL_ITEMS  = 420;

    localparam bit [31:0] INIT_CHAIN [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam bit [31:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam bit [7:0] PAD_MARK     = 8'h80;
    localparam int       LEN_OFFSET   = 56;
    localparam int       BOUNDARY_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef struct {
        bit [31:0] word;
        bit        last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] byte_valid
    logic        s_tlast;   // message_end
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic        m_tlast;   // word_last

    bit [7:0]     msg_block [64];
    bit [5:0]     fill_ptr;
    bit [63:0]    msg_bits;
    bit [31:0]    hash_state [5];
    digest_word_t digest_q [$];
    digest_word_t want;

    bit quiet_mode;
    int requests_sent;
    int messages_sent;
    int words_checked;
    int fail_count;
    int cycle_count;

    sha1_message_digest dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // hash predictor
    // ------------------------------------------------------------------
    function automatic bit [31:0] rol32(input bit [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 5; i++)
            hash_state[i] = INIT_CHAIN[i];
        fill_ptr = '0;
        msg_bits = '0;
    endfunction

    function automatic void absorb_block();
        bit [31:0] w [80];
        bit [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (i = 16; i < 80; i++)
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
                f = (b & c) | (~b & d);
            else if (i < 40 || i >= 60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (b & d) | (c & d);
            k = ROUND_K[i / 20];
            t = rol32(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void predict_request(input bit [7:0] data, input bit with_byte,
                                            input bit is_end);
        int idx;
        int i;
        digest_word_t dw;
        if (with_byte)
        begin
            msg_block[fill_ptr] = data;
            msg_bits += 64'd8;
            fill_ptr++;
            if (fill_ptr == 0)
                absorb_block();
        end
        if (!is_end)
            return;
        idx = int'(fill_ptr);
        msg_block[idx] = PAD_MARK;
        idx++;
        if (idx > LEN_OFFSET)
        begin
            while (idx < 64)
            begin
                msg_block[idx] = 8'h00;
                idx++;
            end
            absorb_block();
            idx = 0;
        end
        while (idx < LEN_OFFSET)
        begin
            msg_block[idx] = 8'h00;
            idx++;
        end
        for (i = 0; i < 8; i++)
            msg_block[LEN_OFFSET + i] = 8'(msg_bits >> (56 - 8 * i));
        absorb_block();
        for (i = 0; i < 5; i++)
        begin
            dw.word = hash_state[i];
            dw.last = (i == 4);
            digest_q.push_back(dw);
        end
        restart_hash();
        messages_sent++;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
                report_mismatch($sformatf("digest word %h with none pending", m_tdata));
            else
            begin
                want = digest_q.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch($sformatf("digest word %h, predicted %h",
                                              m_tdata, want.word));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("word last %b, predicted %b on word %h",
                                              m_tlast, want.last, want.word));
                words_checked++;
            end
        end
    end

    // result side back-pressure
    initial
    begin : sink_ready
        int n;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet_mode && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_request(input bit [7:0] data, input bit with_byte,
                                input bit is_end);
        int gap;
        if (!quiet_mode && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= with_byte;
        s_tlast  <= is_end;
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(data, with_byte, is_end);
        requests_sent++;
    endtask

    task automatic send_bytes(input int len, input int noise_pct);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
    endtask

    task automatic send_message(input int len, input int noise_pct);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        if (end_on_byte)
        begin
            send_bytes(len - 1, noise_pct);
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
        else
        begin
            send_bytes(len, noise_pct);
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    function automatic int pick_length();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 50)
            return int'($urandom_range(0, 8));
        if (roll < 80)
            return int'($urandom_range(9, 70));
        if (roll < 95)
            return BOUNDARY_LEN[$urandom_range(0, 7)];
        return int'($urandom_range(100, 130));
    endfunction

    task automatic wait_digests_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (digest_q.size() != 0);
    endtask

    task automatic test_directed_cases();
        // empty message
        send_request(8'hFF, 1'b0, 1'b1);
        // "abc", last byte carries the end mark
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // ignored requests inside a message, end without a byte
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        // single byte extremes with the end mark
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        // two empty messages back to back
        send_request(8'h5A, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int target);
        while (requests_sent < target)
            send_message(pick_length(), 10);
    endtask

    task automatic test_drain_pause();
        // stop mid-message until all digests are out, then finish it
        send_bytes(int'($urandom_range(20, 60)), 0);
        wait_digests_drained();
        send_message(int'($urandom_range(0, 30)), 0);
    endtask

    task automatic test_streaming_tail();
        quiet_mode = 1'b1;
        while (requests_sent < TOTAL_ITEMS)
            send_message(int'($urandom_range(0, 12)), 0);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        quiet_mode = 1'b0;
        restart_hash();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_messages(RANDOM_SPLIT);
        test_drain_pause();
        test_random_messages(RANDOM_TOTAL);
        test_streaming_tail();

        wait_digests_drained();
        repeat (SETTLE_TIME) @(posedge clk);

        $display("Ran %0d messages from %0d requests; %0d digest words checked.",
                 messages_sent, requests_sent, words_checked);
        $display("Covered empty, block-edge and multi-block messages under random stalls.");
        if (fail_count == 0 && digest_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
